// ----- sv/steering_servo_link_supervisor_assert.svh -----
// assertion macros for the steering servo link supervisor checker
// no dependencies; included by files that carry concurrent assertions
`ifndef STEERING_SERVO_LINK_SUPERVISOR_ASSERT_SVH
`define STEERING_SERVO_LINK_SUPERVISOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SSLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ssls assertion failed");

// next-cycle implication, checked outside reset
`define SSLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ssls assertion failed");

`endif

// ----- sv/ssls_pkg.sv -----
// shared types, constants and helper functions of the steering servo link supervisor
// no dependencies
package ssls_pkg;

    localparam int APB_ADDR_W = 5;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_ZERO_OFFSET    = 3'd0;
    localparam logic [2:0] REG_STARTUP_PERIOD = 3'd1;
    localparam logic [2:0] REG_STARTUP_COUNT  = 3'd2;
    localparam logic [2:0] REG_RECOVER_PERIOD = 3'd3;
    localparam logic [2:0] REG_LINK_TIMEOUT   = 3'd4;

    localparam logic [16:0] RST_ZERO_OFFSET    = 17'd0;
    localparam logic [15:0] RST_STARTUP_PERIOD = 16'd600;
    localparam logic [2:0]  RST_STARTUP_COUNT  = 3'd5;
    localparam logic [15:0] RST_RECOVER_PERIOD = 16'd500;
    localparam logic [15:0] RST_LINK_TIMEOUT   = 16'd1000;

    // op codes
    localparam logic [3:0] OP_RX         = 4'd0;
    localparam logic [3:0] OP_TICK       = 4'd1;
    localparam logic [3:0] OP_CAL_ZERO   = 4'd2;
    localparam logic [3:0] OP_SET_OFFSET = 4'd3;
    localparam logic [3:0] OP_CAL_ANGLE  = 4'd4;
    localparam logic [3:0] OP_ABS_ANGLE  = 4'd5;
    localparam logic [3:0] OP_SPEED      = 4'd6;
    localparam logic [3:0] OP_ENABLE     = 4'd7;
    localparam logic [3:0] OP_DISABLE    = 4'd8;

    // identifiers
    localparam logic [28:0] ID_SERVO_A = 29'h0600_0001;
    localparam logic [28:0] ID_SERVO_B = 29'h0600_0007;
    localparam logic [28:0] ID_HB_A    = 29'h0700_0001;
    localparam logic [28:0] ID_HB_B    = 29'h0700_0007;
    localparam logic [28:0] ID_STD_0   = 29'h0000_0241;
    localparam logic [28:0] ID_STD_1   = 29'h0000_0011;
    localparam logic [28:0] ID_STD_2   = 29'h0000_0017;
    localparam logic [28:0] ID_STD_3   = 29'h0C04_02A1;

    // command payloads
    localparam logic [63:0] MODE_FRAME    = 64'h030D_2031_0000_0000;
    localparam logic [63:0] ENABLE_FRAME  = 64'h230D_2001_0000_0000;
    localparam logic [63:0] DISABLE_FRAME = 64'h230C_2001_0000_0000;
    localparam logic [31:0] COUNT_HDR     = 32'h2302_2001;
    localparam logic [31:0] SPEED_HDR     = 32'h2300_2001;

    // angle count = angle * 5 / 18, division by 18 through reciprocals
    localparam logic [4:0]  SCALE_DIV   = 5'd18;
    localparam logic [11:0] RECIP18_HI  = 12'd3640;     // floor(2^16 / 18)
    localparam logic [20:0] RECIP18_LO  = 21'd1864135;  // floor(2^25 / 18)

    typedef struct packed {
        logic [3:0]         op;
        logic [28:0]        rx_id;
        logic [63:0]        rx_data;
        logic [3:0]         rx_len;
        logic signed [31:0] value;
    } t_item;

    typedef struct packed {
        logic               frame_valid;
        logic [28:0]        frame_id;
        logic [63:0]        frame_data;
        logic               last;
        logic signed [31:0] actual_angle;
        logic signed [31:0] calibrated_angle;
        logic signed [19:0] actual_speed;
        logic               enabled;
        logic               servo_fault;
        logic               hand_override;
        logic signed [31:0] home_angle;
        logic               home_locked;
    } t_result;

    typedef enum logic [1:0] {
        BURST_NONE,
        BURST_PAIR,
        BURST_ENABLE
    } t_burst;

    typedef struct packed {
        logic [31:0] angle;
        logic [31:0] cal;
        logic [19:0] speed;
        logic        enabled;
        logic        error;
        logic        override;
        logic [31:0] home;
        logic        home_ok;
    } t_status;

    typedef struct packed {
        t_burst      burst;
        logic [63:0] data;
        logic        is_angle;
        logic        neg;
        logic [31:0] mag;
        t_status     st;
    } t_desc;

    typedef struct packed {
        logic [15:0] startup_period;
        logic [2:0]  startup_count;
        logic [15:0] recover_period;
        logic [15:0] link_timeout;
        logic        zero_load;
        logic [16:0] zero_value;
    } t_cfg;

    function automatic logic [31:0] f_sat32(input logic [32:0] v);
        logic [31:0] res;
        if (v[32] != v[31]) begin
            res = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // floor(5 * r / 18) for a remainder below 18
    function automatic logic [2:0] f_frac5(input logic [4:0] r);
        logic [2:0] res;
        priority if (r >= 5'd15) begin
            res = 3'd4;
        end else if (r >= 5'd11) begin
            res = 3'd3;
        end else if (r >= 5'd8) begin
            res = 3'd2;
        end else if (r >= 5'd4) begin
            res = 3'd1;
        end else begin
            res = 3'd0;
        end
        return res;
    endfunction

endpackage

// ----- sv/ssls_regs.sv -----
// configuration register file behind the apb-style port
// depends on ssls_pkg
module ssls_regs import ssls_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [16:0] r_zero_init;
    logic [15:0] r_startup_period;
    logic [2:0]  r_startup_count;
    logic [15:0] r_recover_period;
    logic [15:0] r_link_timeout;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_init      <= RST_ZERO_OFFSET;
            r_startup_period <= RST_STARTUP_PERIOD;
            r_startup_count  <= RST_STARTUP_COUNT;
            r_recover_period <= RST_RECOVER_PERIOD;
            r_link_timeout   <= RST_LINK_TIMEOUT;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ZERO_OFFSET:    r_zero_init      <= pwdata[16:0];
                REG_STARTUP_PERIOD: r_startup_period <= pwdata[15:0];
                REG_STARTUP_COUNT:  r_startup_count  <= pwdata[2:0];
                REG_RECOVER_PERIOD: r_recover_period <= pwdata[15:0];
                REG_LINK_TIMEOUT:   r_link_timeout   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ZERO_OFFSET:    prdata = {{15{r_zero_init[16]}}, r_zero_init};
            REG_STARTUP_PERIOD: prdata = {16'd0, r_startup_period};
            REG_STARTUP_COUNT:  prdata = {29'd0, r_startup_count};
            REG_RECOVER_PERIOD: prdata = {16'd0, r_recover_period};
            REG_LINK_TIMEOUT:   prdata = {16'd0, r_link_timeout};
            default:            prdata = 32'd0;
        endcase
    end

    // writing the offset register also reloads the live zero offset, unless a request updates the state in that cycle
    always_comb begin
        o_cfg.startup_period = r_startup_period;
        o_cfg.startup_count  = r_startup_count;
        o_cfg.recover_period = r_recover_period;
        o_cfg.link_timeout   = r_link_timeout;
        o_cfg.zero_load      = wr_en && (reg_idx == REG_ZERO_OFFSET);
        o_cfg.zero_value     = pwdata[16:0];
    end

endmodule

// ----- sv/ssls_decode.sv -----
// input register, frame decode, supervisor state and command descriptor
// depends on ssls_pkg
module ssls_decode import ssls_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_valid,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output logic  o_ready,
    output logic  o_desc_valid,
    output t_desc o_desc
);

    logic        r_in_valid;
    t_item       r_in;

    logic [31:0] r_now, n_now;
    logic [31:0] r_last_rx, n_last_rx;
    logic        r_rx_seen, n_rx_seen;
    logic [31:0] r_last_check, n_last_check;
    logic [2:0]  r_sends_done, n_sends_done;
    logic [31:0] r_zero_offset, n_zero_offset;
    logic [31:0] r_angle, n_angle;
    logic [31:0] r_angle_cal, n_angle_cal;
    logic [19:0] r_speed, n_speed;
    logic        r_enabled, n_enabled;
    logic        r_error, n_error;
    logic        r_override, n_override;
    logic [31:0] r_home, n_home;
    logic        r_home_ok, n_home_ok;
    logic        r_desc_valid;
    t_desc       r_desc, n_desc;

    logic [7:0]  rx_b [8];
    logic        is_hb, is_std, len_ok, len_full;
    logic [31:0] rx_angle, rx_cal, set_cal, cfg_zero, cfg_cal, cmd_angle;
    logic [19:0] rx_speed;
    logic [15:0] hb_code;
    logic [31:0] now_next, since_check, since_rx;
    logic        startup_due, recover_due, link_lost;

    assign o_ready = i_adv;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            rx_b[k] = r_in.rx_data[(63 - 8 * k) -: 8];
        end
    end

    assign is_hb  = (r_in.rx_id == ID_HB_A) || (r_in.rx_id == ID_HB_B);
    assign is_std = (r_in.rx_id == ID_STD_0) || (r_in.rx_id == ID_STD_1) ||
                    (r_in.rx_id == ID_STD_2) || (r_in.rx_id == ID_STD_3);
    assign len_ok   = r_in.rx_len >= 4'd6;
    assign len_full = r_in.rx_len >= 4'd8;
    assign hb_code  = {rx_b[6], rx_b[7]};

    // heartbeat carries whole degrees and rpm, standard frames little-endian raw units
    assign rx_angle = is_hb ? ({{16{rx_b[0][7]}}, rx_b[0], rx_b[1]} * 32'd100)
                            : {rx_b[3], rx_b[2], rx_b[1], rx_b[0]};
    assign rx_speed = is_hb ? ({{4{rx_b[2][7]}}, rx_b[2], rx_b[3]} * 20'd10)
                            : {{4{rx_b[5][7]}}, rx_b[5], rx_b[4]};
    assign rx_cal   = f_sat32({rx_angle[31], rx_angle} - {r_zero_offset[31], r_zero_offset});
    assign set_cal  = f_sat32({r_angle[31], r_angle} - {r_in.value[31], r_in.value});
    assign cfg_zero = {{15{i_cfg.zero_value[16]}}, i_cfg.zero_value};
    assign cfg_cal  = f_sat32({r_angle[31], r_angle} - {cfg_zero[31], cfg_zero});
    assign cmd_angle = (r_in.op == OP_CAL_ANGLE)
                     ? f_sat32({r_in.value[31], r_in.value} + {r_zero_offset[31], r_zero_offset})
                     : r_in.value;

    assign now_next    = r_now + 32'd1;
    assign since_check = now_next - r_last_check;
    assign since_rx    = now_next - r_last_rx;
    assign startup_due = since_check >= {16'd0, i_cfg.startup_period};
    assign recover_due = since_check >= {16'd0, i_cfg.recover_period};
    assign link_lost   = r_rx_seen && (since_rx > {16'd0, i_cfg.link_timeout});

    always_comb begin
        n_now         = r_now;
        n_last_rx     = r_last_rx;
        n_rx_seen     = r_rx_seen;
        n_last_check  = r_last_check;
        n_sends_done  = r_sends_done;
        n_zero_offset = r_zero_offset;
        n_angle       = r_angle;
        n_angle_cal   = r_angle_cal;
        n_speed       = r_speed;
        n_enabled     = r_enabled;
        n_error       = r_error;
        n_override    = r_override;
        n_home        = r_home;
        n_home_ok     = r_home_ok;
        n_desc.burst    = BURST_NONE;
        n_desc.data     = 64'd0;
        n_desc.is_angle = 1'b0;
        n_desc.neg      = 1'b0;
        n_desc.mag      = 32'd0;

        unique case (r_in.op)
            OP_RX: begin
                if (len_ok) begin
                    n_last_rx = r_now;
                    n_rx_seen = 1'b1;
                    if (is_hb || is_std) begin
                        n_angle     = rx_angle;
                        n_angle_cal = rx_cal;
                        n_speed     = rx_speed;
                        n_enabled   = 1'b1;
                    end
                    if (is_hb) begin
                        if (!r_home_ok) begin
                            n_home    = rx_angle;
                            n_home_ok = 1'b1;
                        end
                        if (len_full) begin
                            n_enabled  = ~rx_b[7][0];
                            n_error    = hb_code > 16'd1;
                            n_override = rx_b[6][2];
                        end
                    end
                end
            end
            OP_TICK: begin
                n_now = now_next;
                if (r_sends_done < i_cfg.startup_count) begin
                    if (startup_due) begin
                        n_last_check = now_next;
                        n_enabled    = 1'b1;
                        n_desc.burst = BURST_ENABLE;
                        n_sends_done = r_sends_done + 3'd1;
                    end
                end else if ((!r_enabled || link_lost) && recover_due) begin
                    n_last_check = now_next;
                    n_enabled    = 1'b1;
                    n_desc.burst = BURST_ENABLE;
                end
            end
            OP_CAL_ZERO: begin
                n_zero_offset = r_angle;
                n_angle_cal   = 32'd0;
            end
            OP_SET_OFFSET: begin
                n_zero_offset = r_in.value;
                n_angle_cal   = set_cal;
            end
            OP_CAL_ANGLE, OP_ABS_ANGLE: begin
                n_desc.burst    = BURST_PAIR;
                n_desc.is_angle = 1'b1;
                n_desc.neg      = cmd_angle[31];
                n_desc.mag      = cmd_angle[31] ? (32'd0 - cmd_angle) : cmd_angle;
            end
            OP_SPEED: begin
                n_desc.burst = BURST_PAIR;
                n_desc.data  = {SPEED_HDR, r_in.value[15:0], r_in.value[31:16]};
            end
            OP_ENABLE: begin
                n_enabled    = 1'b1;
                n_desc.burst = BURST_ENABLE;
            end
            OP_DISABLE: begin
                n_enabled    = 1'b0;
                n_desc.burst = BURST_PAIR;
                n_desc.data  = DISABLE_FRAME;
            end
            default: ;
        endcase

        // every result shows the state after the whole request
        n_desc.st.angle    = n_angle;
        n_desc.st.cal      = n_angle_cal;
        n_desc.st.speed    = n_speed;
        n_desc.st.enabled  = n_enabled;
        n_desc.st.error    = n_error;
        n_desc.st.override = n_override;
        n_desc.st.home     = n_home;
        n_desc.st.home_ok  = n_home_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_desc_valid  <= 1'b0;
            r_now         <= 32'd0;
            r_last_rx     <= 32'd0;
            r_rx_seen     <= 1'b0;
            r_last_check  <= 32'd0;
            r_sends_done  <= 3'd0;
            r_zero_offset <= {{15{RST_ZERO_OFFSET[16]}}, RST_ZERO_OFFSET};
            r_angle       <= 32'd0;
            r_angle_cal   <= 32'd0;
            r_speed       <= 20'd0;
            r_enabled     <= 1'b0;
            r_error       <= 1'b0;
            r_override    <= 1'b0;
            r_home        <= 32'd0;
            r_home_ok     <= 1'b0;
        end else begin
            if (i_adv) begin
                r_in_valid   <= i_valid;
                r_desc_valid <= r_in_valid;
            end
            if (i_adv && r_in_valid) begin
                r_now         <= n_now;
                r_last_rx     <= n_last_rx;
                r_rx_seen     <= n_rx_seen;
                r_last_check  <= n_last_check;
                r_sends_done  <= n_sends_done;
                r_zero_offset <= n_zero_offset;
                r_angle       <= n_angle;
                r_angle_cal   <= n_angle_cal;
                r_speed       <= n_speed;
                r_enabled     <= n_enabled;
                r_error       <= n_error;
                r_override    <= n_override;
                r_home        <= n_home;
                r_home_ok     <= n_home_ok;
            end else if (i_cfg.zero_load) begin
                r_zero_offset <= cfg_zero;
                r_angle_cal   <= cfg_cal;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_in   <= i_item;
            r_desc <= n_desc;
        end
    end

    assign o_desc_valid = r_desc_valid;
    assign o_desc       = r_desc;

endmodule

// ----- sv/ssls_scale.sv -----
// angle count pipeline: magnitude * 5 / 18 split into 16-bit halves over three registers
// depends on ssls_pkg
module ssls_scale import ssls_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_valid,
    input  t_desc i_desc,
    output logic  o_valid,
    output t_desc o_desc
);

    logic        r_a_valid, r_b_valid, r_c_valid;
    t_desc       r_a_desc, r_b_desc, r_c_desc;
    logic [11:0] r_a_qhe;
    logic [10:0] r_b_qh, r_c_qh;
    logic [20:0] r_b_m, r_c_m;
    logic [16:0] r_c_qle;

    logic [27:0] hi_prod;
    logic [16:0] hi_rem_raw;
    logic        hi_fix;
    logic [11:0] hi_q;
    logic [4:0]  hi_rem;
    logic [41:0] lo_prod;
    logic [20:0] lo_rem_raw;
    logic        lo_fix;
    logic [16:0] lo_q;
    logic [4:0]  lo_rem;
    logic [26:0] quot;
    logic [31:0] count_mag, count_raw;

    // high half estimate, low by at most one
    assign hi_prod = 28'(i_desc.mag[31:16]) * 28'(RECIP18_HI);

    assign hi_rem_raw = {1'b0, r_a_desc.mag[31:16]} - (17'(r_a_qhe) * 17'(SCALE_DIV));
    assign hi_fix     = hi_rem_raw >= 17'(SCALE_DIV);
    assign hi_q       = hi_fix ? (r_a_qhe + 12'd1) : r_a_qhe;
    assign hi_rem     = hi_fix ? 5'(hi_rem_raw - 17'(SCALE_DIV)) : hi_rem_raw[4:0];

    // remainder of high half joined with the low half, below 18 * 2^16
    assign lo_prod = 42'(r_b_m) * 42'(RECIP18_LO);

    assign lo_rem_raw = r_c_m - (21'(r_c_qle) * 21'(SCALE_DIV));
    assign lo_fix     = lo_rem_raw >= 21'(SCALE_DIV);
    assign lo_q       = lo_fix ? (r_c_qle + 17'd1) : r_c_qle;
    assign lo_rem     = lo_fix ? 5'(lo_rem_raw - 21'(SCALE_DIV)) : lo_rem_raw[4:0];

    assign quot      = {r_c_qh, lo_q[15:0]};
    assign count_mag = (32'(quot) * 32'd5) + 32'(f_frac5(lo_rem));
    assign count_raw = r_c_desc.neg ? (32'd0 - count_mag) : count_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_adv) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_desc <= i_desc;
            r_a_qhe  <= hi_prod[27:16];
            r_b_desc <= r_a_desc;
            r_b_qh   <= hi_q[10:0];
            r_b_m    <= {hi_rem, r_a_desc.mag[15:0]};
            r_c_desc <= r_b_desc;
            r_c_qh   <= r_b_qh;
            r_c_m    <= r_b_m;
            r_c_qle  <= lo_prod[41:25];
        end
    end

    always_comb begin
        o_desc = r_c_desc;
        if (r_c_desc.is_angle) begin
            o_desc.data = {COUNT_HDR, count_raw[15:0], count_raw[31:16]};
        end
    end

    assign o_valid = r_c_valid;

endmodule

// ----- sv/ssls_outbuf.sv -----
// result register: holds one descriptor and sends its frames one per request
// depends on ssls_pkg
module ssls_outbuf import ssls_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_desc   i_desc,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_result,
    output logic    o_adv
);

    logic       r_valid;
    logic [1:0] r_beat;
    t_desc      r_desc;
    logic       last_beat;

    always_comb begin
        o_result.frame_valid = 1'b1;
        o_result.frame_id    = r_beat[0] ? ID_SERVO_B : ID_SERVO_A;
        o_result.frame_data  = r_desc.data;
        last_beat            = 1'b1;
        unique case (r_desc.burst)
            BURST_NONE: begin
                o_result.frame_valid = 1'b0;
                o_result.frame_id    = 29'd0;
                o_result.frame_data  = 64'd0;
            end
            BURST_PAIR: begin
                last_beat = r_beat == 2'd1;
            end
            BURST_ENABLE: begin
                // mode frame to both ids, then the enable frame to both
                o_result.frame_data = r_beat[1] ? ENABLE_FRAME : MODE_FRAME;
                last_beat           = r_beat == 2'd3;
            end
            default: begin
                o_result.frame_valid = 1'b0;
                o_result.frame_id    = 29'd0;
                o_result.frame_data  = 64'd0;
            end
        endcase
        o_result.last             = last_beat;
        o_result.actual_angle     = r_desc.st.angle;
        o_result.calibrated_angle = r_desc.st.cal;
        o_result.actual_speed     = r_desc.st.speed;
        o_result.enabled          = r_desc.st.enabled;
        o_result.servo_fault      = r_desc.st.error;
        o_result.hand_override    = r_desc.st.override;
        o_result.home_angle       = r_desc.st.home;
        o_result.home_locked      = r_desc.st.home_ok;
    end

    assign o_valid = r_valid;
    assign o_adv   = !r_valid || (i_ready && last_beat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= 2'd0;
        end else if (o_adv) begin
            r_valid <= i_valid;
            r_beat  <= 2'd0;
        end else if (i_ready) begin
            r_beat <= r_beat + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_desc <= i_desc;
        end
    end

endmodule

// ----- sv/steering_servo_link_supervisor.sv -----
// throughput: one request per cycle while the result side is ready; a request with
// several command frames holds the result register until its last frame is taken
// (two frames for angle, speed and disable, four for enable)
// the pipeline moves as one: input register, decode, three scaling stages, result
// reset: synchronous active low, clears all supervisor state and loads register defaults
module steering_servo_link_supervisor import ssls_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_item                 i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_result               o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cfg  cfg;
    logic  adv;
    logic  dec_valid, scl_valid;
    t_desc dec_desc, scl_desc;

    ssls_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ssls_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_valid      (i_valid),
        .i_item       (i_item),
        .i_cfg        (cfg),
        .o_ready      (o_ready),
        .o_desc_valid (dec_valid),
        .o_desc       (dec_desc)
    );

    ssls_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (dec_valid),
        .i_desc  (dec_desc),
        .o_valid (scl_valid),
        .o_desc  (scl_desc)
    );

    ssls_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (scl_valid),
        .i_desc   (scl_desc),
        .i_ready  (i_ready),
        .o_valid  (o_valid),
        .o_result (o_result),
        .o_adv    (adv)
    );

endmodule

// ----- sv/ssls_checker.sv -----
// port-level checks on the result channel of the supervisor, bound to the top level
// depends on ssls_pkg and steering_servo_link_supervisor_assert.svh
`include "steering_servo_link_supervisor_assert.svh"

module ssls_checker import ssls_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    o_valid,
    input logic    i_ready,
    input t_result o_result
);

    `SSLS_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_result))
    `SSLS_ASSERT_NOW(a_status_only_single, i_clk, i_rst_n, o_valid && !o_result.frame_valid, o_result.last && (o_result.frame_id == 29'd0) && (o_result.frame_data == 64'd0))
    `SSLS_ASSERT_NOW(a_frame_id_known, i_clk, i_rst_n, o_valid && o_result.frame_valid, (o_result.frame_id == ID_SERVO_A) || (o_result.frame_id == ID_SERVO_B))
    `SSLS_ASSERT_NOW(a_first_id_not_last, i_clk, i_rst_n, o_valid && o_result.frame_valid && (o_result.frame_id == ID_SERVO_A), !o_result.last)
    `SSLS_ASSERT_NEXT(a_pair_follows, i_clk, i_rst_n, o_valid && i_ready && o_result.frame_valid && (o_result.frame_id == ID_SERVO_A), o_valid && (o_result.frame_id == ID_SERVO_B))

endmodule

bind steering_servo_link_supervisor ssls_checker u_checker (.*);

// ----- test/testbench.sv -----
// self-checking testbench for the steering servo link supervisor: a stimulus table, then random
// requests over several register settings, checked against an in-bench model of the supervisor
// depends on ssls_pkg and steering_servo_link_supervisor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ssls_pkg::*;

    localparam logic [3:0]  OP_SPARE_LO   = 4'd9;
    localparam logic [3:0]  OP_SPARE_HI   = 4'd15;
    localparam logic [28:0] ID_SDO_REPLY  = 29'h0580_0001;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          TAIL_CYCLES   = 20;
    localparam int          REQS_PER_PHASE = 60;
    localparam int          PHASES        = 5;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    t_item                 i_item;
    logic                  o_valid;
    logic                  i_ready;
    t_result               o_result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    steering_servo_link_supervisor u_top (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item, .o_valid, .i_ready, .o_result,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    // register copies
    logic signed [16:0] zero_init_reg;
    logic [15:0]        boot_period;
    logic [2:0]         boot_count;
    logic [15:0]        recover_period;
    logic [15:0]        link_timeout;

    // supervisor state as predicted
    logic [31:0]        ms_now;
    logic [31:0]        rx_last_ms;
    logic               link_heard;
    logic [31:0]        check_ms;
    logic [2:0]         boot_enables;
    logic signed [31:0] zero_ref;
    logic signed [31:0] angle_cd;
    logic signed [31:0] angle_cal;
    logic signed [19:0] speed_dr;
    logic               srv_enabled;
    logic               srv_error;
    logic               srv_override;
    logic signed [31:0] home_cd;
    logic               home_valid;

    logic [28:0] cmd_ids[$];
    logic [63:0] cmd_words[$];
    t_result     step_out[$];
    t_result     due_results[$];

    t_item   plan_req[$];
    bit      plan_typed[$];
    t_result plan_want[$];

    t_result want;
    t_result head;
    int      mismatches = 0;
    int      cycles = 0;
    int      stall_left = 0;
    bit      idle_on = 1'b0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (!idle_on) begin
            i_ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 9) == 0) begin
            i_ready <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end else begin
            i_ready <= 1'b1;
        end
    end

    function automatic string describe(input t_result r);
        return $sformatf("fv %0b id %h data %h last %0b ang %0d cal %0d spd %0d en %0b err %0b ovr %0b home %0d/%0b",
            r.frame_valid, r.frame_id, r.frame_data, r.last, r.actual_angle,
            r.calibrated_angle, r.actual_speed, r.enabled, r.servo_fault,
            r.hand_override, r.home_angle, r.home_locked);
    endfunction

    task automatic report_mismatch(input string what, input t_result exp_r, input t_result got_r);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s at cycle %0d", what, cycles);
            $display("  expected %s", describe(exp_r));
            $display("  actual   %s", describe(got_r));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("result with no request outstanding", '0, o_result);
            end else begin
                head = due_results.pop_front();
                if (o_result !== head) begin
                    report_mismatch("result mismatch", head, o_result);
                end
            end
        end
    end

    function automatic logic signed [31:0] sat_combine(input logic signed [31:0] a,
                                                      input logic signed [31:0] b,
                                                      input bit subtract);
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        logic signed [63:0] total;
        wa = a;
        wb = b;
        total = subtract ? wa - wb : wa + wb;
        if (total > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (total < -64'sd2147483648) return 32'sh8000_0000;
        return total[31:0];
    endfunction

    // set-point payload, bytes 4..7 carry the word in mid-endian order
    function automatic logic [63:0] motion_word(input logic [31:0] hdr, input logic [31:0] u);
        return {hdr, u[15:8], u[7:0], u[31:24], u[23:16]};
    endfunction

    task automatic queue_pair(input logic [63:0] d);
        if (cmd_ids.size() <= 2) begin
            cmd_ids.push_back(ID_SERVO_A);
            cmd_words.push_back(d);
            cmd_ids.push_back(ID_SERVO_B);
            cmd_words.push_back(d);
        end
    endtask

    task automatic order_enable();
        queue_pair(MODE_FRAME);
        queue_pair(ENABLE_FRAME);
        srv_enabled = 1'b1;
    endtask

    task automatic order_angle(input logic signed [31:0] centideg);
        logic signed [63:0] wide;
        logic signed [63:0] counts;
        wide = centideg;
        counts = (wide * 64'sd5) / 64'sd18;
        queue_pair(motion_word(COUNT_HDR, counts[31:0]));
    endtask

    task automatic take_frame(input logic [28:0] id, input logic [63:0] d, input logic [3:0] len);
        logic [7:0]         b[0:7];
        logic signed [15:0] s16;
        logic [15:0]        code;
        if (len < 4'd6) return;
        for (int k = 0; k < 8; k++) b[k] = d[63 - 8 * k -: 8];
        rx_last_ms = ms_now;
        link_heard = 1'b1;
        if (id == ID_HB_A || id == ID_HB_B) begin
            s16 = {b[0], b[1]};
            angle_cd = s16 * 32'sd100;
            angle_cal = sat_combine(angle_cd, zero_ref, 1'b1);
            s16 = {b[2], b[3]};
            speed_dr = s16 * 20'sd10;
            if (!home_valid) begin
                home_cd = angle_cd;
                home_valid = 1'b1;
            end
            if (len >= 4'd8) begin
                code = {b[6], b[7]};
                srv_enabled = !b[7][0];
                srv_error = code > 16'd1;
                srv_override = b[6][2];
            end else begin
                srv_enabled = 1'b1;
            end
        end else if (id == ID_STD_0 || id == ID_STD_1 || id == ID_STD_2 || id == ID_STD_3) begin
            angle_cd = {b[3], b[2], b[1], b[0]};
            angle_cal = sat_combine(angle_cd, zero_ref, 1'b1);
            s16 = {b[5], b[4]};
            speed_dr = s16;
            srv_enabled = 1'b1;
        end
    endtask

    task automatic ms_tick();
        logic lost;
        ms_now = ms_now + 32'd1;
        if (boot_enables < boot_count) begin
            if (ms_now - check_ms >= boot_period) begin
                check_ms = ms_now;
                order_enable();
                boot_enables = boot_enables + 3'd1;
            end
        end else begin
            lost = link_heard && (ms_now - rx_last_ms > link_timeout);
            if (!srv_enabled || lost) begin
                if (ms_now - check_ms >= recover_period) begin
                    check_ms = ms_now;
                    order_enable();
                end
            end
        end
    endtask

    // works out the command frames and status that one request produces
    task automatic supervise(input t_item it);
        int      n;
        t_result r;
        cmd_ids.delete();
        cmd_words.delete();
        step_out.delete();
        case (it.op)
            OP_RX:         take_frame(it.rx_id, it.rx_data, it.rx_len);
            OP_TICK:       ms_tick();
            OP_CAL_ZERO: begin
                zero_ref = angle_cd;
                angle_cal = '0;
            end
            OP_SET_OFFSET: begin
                zero_ref = it.value;
                angle_cal = sat_combine(angle_cd, zero_ref, 1'b1);
            end
            OP_CAL_ANGLE:  order_angle(sat_combine(it.value, zero_ref, 1'b0));
            OP_ABS_ANGLE:  order_angle(it.value);
            OP_SPEED:      queue_pair(motion_word(SPEED_HDR, it.value));
            OP_ENABLE:     order_enable();
            OP_DISABLE: begin
                queue_pair(DISABLE_FRAME);
                srv_enabled = 1'b0;
            end
            default: ;
        endcase
        n = (cmd_ids.size() > 0) ? cmd_ids.size() : 1;
        for (int k = 0; k < n; k++) begin
            r = '0;
            if (cmd_ids.size() > 0) begin
                r.frame_valid = 1'b1;
                r.frame_id = cmd_ids[k];
                r.frame_data = cmd_words[k];
            end
            r.last = (k == n - 1);
            r.actual_angle = angle_cd;
            r.calibrated_angle = angle_cal;
            r.actual_speed = speed_dr;
            r.enabled = srv_enabled;
            r.servo_fault = srv_error;
            r.hand_override = srv_override;
            r.home_angle = home_cd;
            r.home_locked = home_valid;
            step_out.push_back(r);
        end
    endtask

    task automatic clear_model();
        zero_init_reg = RST_ZERO_OFFSET;
        boot_period = RST_STARTUP_PERIOD;
        boot_count = RST_STARTUP_COUNT;
        recover_period = RST_RECOVER_PERIOD;
        link_timeout = RST_LINK_TIMEOUT;
        ms_now = '0;
        rx_last_ms = '0;
        link_heard = 1'b0;
        check_ms = '0;
        boot_enables = '0;
        zero_ref = zero_init_reg;
        angle_cd = '0;
        angle_cal = '0;
        speed_dr = '0;
        srv_enabled = 1'b0;
        srv_error = 1'b0;
        srv_override = 1'b0;
        home_cd = '0;
        home_valid = 1'b0;
    endtask

    // psel is left high so that writes can run back to back
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_ZERO_OFFSET: begin
                zero_init_reg = val[16:0];
                zero_ref = zero_init_reg;
                angle_cal = sat_combine(angle_cd, zero_ref, 1'b1);
            end
            REG_STARTUP_PERIOD: boot_period = val[15:0];
            REG_STARTUP_COUNT:  boot_count = val[2:0];
            REG_RECOVER_PERIOD: recover_period = val[15:0];
            REG_LINK_TIMEOUT:   link_timeout = val[15:0];
            default: ;
        endcase
    endtask

    task automatic program_phase(input int zero, input int sp, input int sc, input int rp,
                                 input int lt);
        write_reg(REG_ZERO_OFFSET, zero);
        write_reg(REG_STARTUP_PERIOD, sp);
        write_reg(REG_STARTUP_COUNT, sc);
        write_reg(REG_RECOVER_PERIOD, rp);
        write_reg(REG_LINK_TIMEOUT, lt);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_request(input t_item it, input bit typed, input t_result exp_r,
                                input bit hold);
        if ((hold || (idle_on && $urandom_range(0, 39) == 0)) && due_results.size() != 0) begin
            i_valid <= 1'b0;
            while (due_results.size() != 0) @(posedge i_clk);
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        supervise(it);
        if (typed) begin
            due_results.push_back(exp_r);
        end else begin
            foreach (step_out[k]) due_results.push_back(step_out[k]);
        end
    endtask

    task automatic table_row(input logic [3:0] op, input logic [28:0] id, input logic [63:0] d,
                             input logic [3:0] len, input logic [31:0] val, input bit typed,
                             input t_result exp_r);
        t_item it;
        it.op = op;
        it.rx_id = id;
        it.rx_data = d;
        it.rx_len = len;
        it.value = val;
        plan_req.push_back(it);
        plan_typed.push_back(typed);
        plan_want.push_back(exp_r);
    endtask

    function automatic t_item random_request();
        t_item it;
        int    pick;
        it.op = OP_TICK;
        it.rx_id = 29'($urandom);
        it.rx_data = {$urandom, $urandom};
        it.rx_len = 4'($urandom_range(6, 8));
        it.value = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            it.op = OP_RX;
            case ($urandom_range(0, 9))
                0, 1:    it.rx_id = ID_HB_A;
                2, 3:    it.rx_id = ID_HB_B;
                4:       it.rx_id = ID_STD_0;
                5:       it.rx_id = ID_STD_1;
                6:       it.rx_id = ID_STD_2;
                7:       it.rx_id = ID_STD_3;
                8:       it.rx_id = ID_SDO_REPLY;
                default: ;
            endcase
            if ($urandom_range(0, 4) == 0) it.rx_len = 4'($urandom_range(0, 15));
            // small status codes so that enable and error flags both move
            if ($urandom_range(0, 1) == 1) begin
                it.rx_data[15:0] = 16'($urandom_range(0, 3)) |
                                   (($urandom_range(0, 1) == 1) ? 16'h0400 : 16'h0000);
            end
        end else if (pick < 65) begin
            it.op = OP_TICK;
        end else if (pick < 96) begin
            it.op = 4'($urandom_range(OP_CAL_ZERO, OP_DISABLE));
        end else begin
            it.op = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end
        case ($urandom_range(0, 3))
            0: ;
            1: it.value = int'($urandom_range(0, 72000)) - 36000;
            2: it.value = ($urandom_range(0, 1) == 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: it.value = int'($urandom_range(0, 2000)) - 1000;
        endcase
        return it;
    endfunction

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_item <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        clear_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // status straight after reset, and a short frame that must change nothing
        want = '0;
        want.last = 1'b1;
        table_row(OP_SPARE_HI, '0, '0, '0, '0, 1'b1, want);
        table_row(OP_RX, ID_HB_A, 64'hFFFF_FFFF_FFFF_FFFF, 4'd5, '0, 1'b1, want);
        // most negative heartbeat angle and speed, error code, home captured
        want.actual_angle = -32'sd3276800;
        want.calibrated_angle = -32'sd3276800;
        want.actual_speed = -20'sd327680;
        want.enabled = 1'b1;
        want.servo_fault = 1'b1;
        want.home_angle = -32'sd3276800;
        want.home_locked = 1'b1;
        table_row(OP_RX, ID_HB_A, 64'h8000_8000_0000_0006, 4'd8, '0, 1'b1, want);
        table_row(OP_RX, ID_HB_B, 64'h7FFF_7FFF_0000_0401, 4'd15, '0, 1'b0, '0);
        table_row(OP_RX, ID_HB_A, 64'h0000_0000_0000_0000, 4'd7, '0, 1'b0, '0);
        table_row(OP_RX, ID_STD_0, 64'h0000_0080_FF7F_0000, 4'd8, '0, 1'b0, '0);
        table_row(OP_RX, ID_STD_1, 64'hFFFF_FF7F_0080_0000, 4'd6, '0, 1'b0, '0);
        table_row(OP_RX, ID_STD_2, 64'h1027_0000_6400_1234, 4'd8, '0, 1'b0, '0);
        table_row(OP_RX, ID_STD_3, 64'h9CFF_FFFF_9CFF_0000, 4'd6, '0, 1'b0, '0);
        table_row(OP_RX, ID_SDO_REPLY, 64'h4B02_2001_2300_0000, 4'd8, '0, 1'b0, '0);
        table_row(OP_TICK, '0, '0, '0, '0, 1'b0, '0);
        table_row(OP_CAL_ZERO, '0, '0, '0, '0, 1'b0, '0);
        table_row(OP_SET_OFFSET, '0, '0, '0, 32'sh7FFF_FFFF, 1'b0, '0);
        table_row(OP_RX, ID_STD_0, 64'h0000_0080_FF7F_0000, 4'd8, '0, 1'b0, '0);
        table_row(OP_CAL_ANGLE, '0, '0, '0, 32'sh7FFF_FFFF, 1'b0, '0);
        table_row(OP_SET_OFFSET, '0, '0, '0, 32'sh8000_0000, 1'b0, '0);
        table_row(OP_CAL_ANGLE, '0, '0, '0, 32'sh8000_0000, 1'b0, '0);
        table_row(OP_ABS_ANGLE, '0, '0, '0, 32'sh7FFF_FFFF, 1'b0, '0);
        table_row(OP_ABS_ANGLE, '0, '0, '0, 32'sh8000_0000, 1'b0, '0);
        table_row(OP_ABS_ANGLE, '0, '0, '0, -32'sd17, 1'b0, '0);
        table_row(OP_SPEED, '0, '0, '0, 32'sh7FFF_FFFF, 1'b0, '0);
        table_row(OP_SPEED, '0, '0, '0, -32'sd1, 1'b0, '0);
        table_row(OP_ENABLE, '0, '0, '0, '0, 1'b0, '0);
        table_row(OP_DISABLE, '0, '0, '0, '0, 1'b0, '0);
        table_row(OP_SPARE_LO, '0, '0, '0, '0, 1'b0, '0);

        for (int r = 0; r < plan_req.size(); r++) begin
            send_request(plan_req[r], plan_typed[r], plan_want[r], 1'b0);
        end

        for (int ph = 1; ph <= PHASES; ph++) begin
            wait_for_results();
            case (ph)
                1: program_phase(-36000, 1, 7, 1, 1);
                // zero periods let recovery fire on any tick while disabled or the link is lost
                2: program_phase(36000, 0, 0, 0, 65535);
                3: program_phase(int'($urandom_range(0, 72000)) - 36000, 65535, 3, 65535, 3);
                default: program_phase(int'($urandom_range(0, 72000)) - 36000,
                                       $urandom_range(1, 12), $urandom_range(0, 7),
                                       $urandom_range(1, 12), $urandom_range(1, 30));
            endcase
            idle_on = (ph < PHASES);
            for (int k = 0; k < REQS_PER_PHASE; k++) begin
                send_request(random_request(), 1'b0, '0, ph == 1 && k == REQS_PER_PHASE / 2);
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
